>>> src/isqrt_pkg.sv
package isqrt_pkg;

	// Fixed field widths of the stream payloads
	localparam int unsigned RADICAND_W = 64;
	localparam int unsigned ROOT_W     = 32;

	// Default number of radicand bits processed
	localparam int unsigned RADICAND_WIDTH_DEF = 64;

endpackage

>>> src/isqrt_if.sv
// Radicand stream
interface isqrt_operand_if;
	logic                                 valid;
	logic                                 ready;
	logic [isqrt_pkg::RADICAND_W-1:0]     radicand;

	modport source (output valid, output radicand, input ready);
	modport sink   (input valid, input radicand, output ready);
endinterface

// Root stream
interface isqrt_result_if;
	logic                             valid;
	logic                             ready;
	logic [isqrt_pkg::ROOT_W-1:0]     root;

	modport source (output valid, output root, input ready);
	modport sink   (input valid, input root, output ready);
endinterface

>>> src/isqrt_stage.sv
// One step of the restoring square-root recurrence, with its own register
// stage. Brings down the top two bits of x and decides one root bit.
module isqrt_stage #(
	parameter int unsigned XW = 64,
	parameter int unsigned QW = 32,
	parameter int unsigned RW = QW + 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [XW-1:0] in_x,
	input  logic [RW-1:0] in_rem,
	input  logic [QW-1:0] in_root,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [XW-1:0] out_x,
	output logic [RW-1:0] out_rem,
	output logic [QW-1:0] out_root
);

	logic          valid_s;
	logic [XW-1:0] x_s;
	logic [RW-1:0] rem_s;
	logic [QW-1:0] root_s;

	logic [RW-1:0] rem_sh;
	logic [RW-1:0] trial;
	logic          take;
	logic          advance;

	// Trial subtraction: (rem << 2 | next pair) against (root << 2 | 1)
	assign rem_sh = RW'({in_rem, in_x[XW-1 -: 2]});
	assign trial  = RW'({in_root, 2'b01});
	assign take   = (rem_sh >= trial);

	// Stage moves when empty or when the next stage takes its beat
	assign in_ready = !valid_s || out_ready;
	assign advance  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (in_ready) begin
			valid_s <= in_valid;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (advance) begin
			x_s    <= XW'({in_x, 2'b00});
			rem_s  <= take ? (rem_sh - trial) : rem_sh;
			root_s <= QW'({in_root, take});
		end
	end

	assign out_valid = valid_s;
	assign out_x     = x_s;
	assign out_rem   = rem_s;
	assign out_root  = root_s;

endmodule

>>> src/integer_square_root_floor.sv
// Floor square root of an unsigned radicand, one recurrence step per stage.
// The result beat is registered through the chain of per-bit pipeline stages.
// Throughput: one beat per cycle; each stage holds under backpressure.
// Reset: arst_n clears every stage valid bit; the pipeline comes up empty.
module integer_square_root_floor #(
	parameter int unsigned RADICAND_WIDTH = isqrt_pkg::RADICAND_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	isqrt_operand_if.sink        operand,
	isqrt_result_if.source       result
);

	localparam int unsigned PAIRS = (RADICAND_WIDTH + 1) / 2;
	localparam int unsigned XW    = 2 * PAIRS;
	localparam int unsigned QW    = PAIRS;
	localparam int unsigned RW    = PAIRS + 2;

	logic          vld   [0:PAIRS];
	logic          rdy   [0:PAIRS];
	logic [XW-1:0] x_w   [0:PAIRS];
	logic [RW-1:0] rem_w [0:PAIRS];
	logic [QW-1:0] root_w[0:PAIRS];

	// Entry: bits above the width are dropped, odd widths padded on top
	assign vld[0]    = operand.valid;
	assign operand.ready = rdy[0];
	assign x_w[0]    = XW'(operand.radicand[RADICAND_WIDTH-1:0]);
	assign rem_w[0]  = '0;
	assign root_w[0] = '0;

	// One stage per root bit, most significant first
	for (genvar i = 0; i < PAIRS; i++) begin : g_step
		isqrt_stage #(
			.XW (XW),
			.QW (QW),
			.RW (RW)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld[i]),
			.in_ready  (rdy[i]),
			.in_x      (x_w[i]),
			.in_rem    (rem_w[i]),
			.in_root   (root_w[i]),
			.out_valid (vld[i+1]),
			.out_ready (rdy[i+1]),
			.out_x     (x_w[i+1]),
			.out_rem   (rem_w[i+1]),
			.out_root  (root_w[i+1])
		);
	end

	// Last stage register is the output register
	assign result.valid = vld[PAIRS];
	assign rdy[PAIRS]   = result.ready;
	assign result.root  = isqrt_pkg::ROOT_W'(root_w[PAIRS]);

	// Final remainder must be below 2*root+1, i.e. (root+1)^2 exceeds radicand
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (rem_w[PAIRS] <= RW'({root_w[PAIRS], 1'b0})))
		else $error("remainder out of range at output");

	// An accepted beat lands in the first stage
	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(operand.valid && operand.ready) |=> vld[1])
		else $error("accepted beat missing from first stage");

	// Input only backs up when the first stage holds a beat
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!operand.ready |-> vld[1])
		else $error("input stalled with empty first stage");

endmodule
